// ----- design/itl_pkg.sv -----
// shared types and constants for the inactivity timeout list
package itl_pkg;

	// operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_ARM    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} itl_op_t;

	// register index decoded from paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;

	// reset value of the timeout register
	localparam logic [15:0] TIMEOUT_RESET = 16'd300;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // latch input transaction
		logic rd_slot;    // read links of the addressed slot
		logic unlink;     // unlink the addressed slot if listed
		logic rd_newest;  // read alarm of newest entry
		logic append;     // append the addressed slot at the newest end
		logic rd_oldest;  // read alarm and newer link of oldest entry
		logic pop;        // expire oldest entry into the pending result
		logic emit;       // send pending result, if any
		logic emit_last;  // mark the sent result as last of the run
	} itl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		itl_op_t op;          // latched operation
		logic    oldest_null; // list is empty
		logic    expire;      // oldest alarm lies before now
	} itl_sts_t;

endpackage

// ----- design/itl_ctrl.sv -----
// controller state machine of the inactivity timeout list
module itl_ctrl
	import itl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  itl_op_t  op,
	input  itl_sts_t sts,
	output logic     busy,
	output itl_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_RD_SLOT   = 7'b0000010,
		ST_UNLINK    = 7'b0000100,
		ST_RD_NEW    = 7'b0001000,
		ST_APPEND    = 7'b0010000,
		ST_TICK_RD   = 7'b0100000,
		ST_TICK_EVAL = 7'b1000000
	} itl_state_t;

	itl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (op) inside
						OP_TICK:           state_d = ST_TICK_RD;
						OP_ARM, OP_REMOVE: state_d = ST_RD_SLOT;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_SLOT: begin
				cmd.rd_slot = 1'b1;
				state_d     = ST_UNLINK;
			end
			ST_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = (sts.op == OP_ARM) ? ST_RD_NEW : ST_IDLE;
			end
			ST_RD_NEW: begin
				cmd.rd_newest = 1'b1;
				state_d       = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_TICK_RD: begin
				if (sts.oldest_null) begin
					// list exhausted: close the run
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.rd_oldest = 1'b1;
					state_d       = ST_TICK_EVAL;
				end
			end
			ST_TICK_EVAL: begin
				cmd.emit = 1'b1;
				if (sts.expire) begin
					cmd.pop = 1'b1;
					state_d = ST_TICK_RD;
				end else begin
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/itl_dpath.sv -----
// datapath of the inactivity timeout list: link stores, pointers, alarms
module itl_dpath
	import itl_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  itl_cmd_t    cmd,
	output itl_sts_t    sts,
	input  itl_op_t     op,
	input  logic [3:0]  slot,
	input  logic [31:0] cur_time,
	input  logic [15:0] timeout,
	output logic        result_valid,
	output logic [3:0]  expired_slot,
	output logic        last_of_run
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int TW = TIME_BITS;
	localparam logic [LW-1:0] NUL = LW'(SLOTS);

	// stores
	logic [TW-1:0] alarm_time_q [SLOTS];
	logic [LW-1:0] older_link_q [SLOTS];
	logic [LW-1:0] newer_link_q [SLOTS];
	logic [SLOTS-1:0] listed_q;
	logic [LW-1:0] oldest_q, newest_q;

	// latched transaction
	itl_op_t       op_q;
	logic [IW-1:0] slot_q;
	logic          slot_ok_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] sat_q;

	// registered read data
	logic [TW-1:0] alarm_rd_q;
	logic [LW-1:0] older_rd_q, newer_rd_q;

	// pending expiry result
	logic [IW-1:0] pend_q;
	logic          pend_valid_q;

	logic [31:0]   slot_w;
	logic [63:0]   now_w;
	logic [TW:0]   sum;
	logic [LW-1:0] slot_l, unl_o, unl_n, pop_n, app_alarm_sel;
	logic [TW-1:0] app_alarm;
	logic          do_unlink, do_append;
	logic [31:0]   pend_w;

	assign slot_w = 32'(slot);
	assign now_w  = 64'(cur_time);
	assign slot_l = LW'(slot_q);

	// input latch and saturating alarm sum
	assign sum = {1'b0, now_q} + (TW + 1)'(timeout);
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op;
			slot_q    <= slot_w[IW-1:0];
			slot_ok_q <= (slot_w < 32'(SLOTS));
			now_q     <= now_w[TW-1:0];
		end
		if (cmd.rd_slot) begin
			sat_q <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
		end
	end

	// store reads
	always_ff @(posedge clk) begin
		if (cmd.rd_slot) begin
			older_rd_q <= older_link_q[slot_q];
			newer_rd_q <= newer_link_q[slot_q];
		end else if (cmd.rd_oldest) begin
			newer_rd_q <= newer_link_q[oldest_q[IW-1:0]];
		end
		if (cmd.rd_oldest) begin
			alarm_rd_q <= alarm_time_q[oldest_q[IW-1:0]];
		end else if (cmd.rd_newest) begin
			alarm_rd_q <= alarm_time_q[newest_q[IW-1:0]];
		end
	end

	// neighbors of the slot being unlinked; list ends come from the pointers
	assign unl_o     = (slot_l == oldest_q) ? NUL : older_rd_q;
	assign unl_n     = (slot_l == newest_q) ? NUL : newer_rd_q;
	assign do_unlink = cmd.unlink && slot_ok_q && listed_q[slot_q];
	assign do_append = cmd.append && slot_ok_q;

	// next oldest after a tick expiry
	assign pop_n = (oldest_q == newest_q) ? NUL : newer_rd_q;

	// alarm of the appended slot, kept no earlier than the newest one
	assign app_alarm_sel = newest_q;
	assign app_alarm = (app_alarm_sel != NUL && alarm_rd_q > sat_q) ? alarm_rd_q : sat_q;

	// older link store write
	always_ff @(posedge clk) begin
		if (do_unlink && unl_n != NUL) begin
			older_link_q[unl_n[IW-1:0]] <= unl_o;
		end else if (do_append) begin
			older_link_q[slot_q] <= newest_q;
		end
	end

	// newer link store write
	always_ff @(posedge clk) begin
		if (do_unlink && unl_o != NUL) begin
			newer_link_q[unl_o[IW-1:0]] <= unl_n;
		end else if (do_append && newest_q != NUL) begin
			newer_link_q[newest_q[IW-1:0]] <= slot_l;
		end
	end

	// alarm store write
	always_ff @(posedge clk) begin
		if (do_append) begin
			alarm_time_q[slot_q] <= app_alarm;
		end
	end

	// list pointers and listed flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			oldest_q <= NUL;
			newest_q <= NUL;
		end else if (do_unlink) begin
			listed_q[slot_q] <= 1'b0;
			if (unl_n == NUL) newest_q <= unl_o;
			if (unl_o == NUL) oldest_q <= unl_n;
		end else if (do_append) begin
			listed_q[slot_q] <= 1'b1;
			if (oldest_q == NUL) oldest_q <= slot_l;
			newest_q <= slot_l;
		end else if (cmd.pop) begin
			listed_q[oldest_q[IW-1:0]] <= 1'b0;
			oldest_q <= pop_n;
			if (pop_n == NUL) newest_q <= NUL;
		end
	end

	// pending result holder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.emit && cmd.emit_last) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pend_q <= oldest_q[IW-1:0];
		end
	end

	// result strobe and fields
	assign pend_w = 32'(pend_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit && pend_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			expired_slot <= pend_w[3:0];
			last_of_run  <= cmd.emit_last;
		end
	end

	// status to controller
	assign sts.op          = op_q;
	assign sts.oldest_null = (oldest_q == NUL);
	assign sts.expire      = (oldest_q != NUL) && (now_q > alarm_rd_q);

endmodule

// ----- design/inactivity_timeout_list_unit.sv -----
// top level of the inactivity timeout list with its register port
// Each transaction is accepted when start is high and busy is low; op 1 arms or
// defers a slot, op 2 removes it, op 0 ticks and expires every slot whose alarm
// lies strictly before cur_time, oldest first. Busy stays high while the
// controller walks the link stores, one read and one update per step.
// Expired slots come out one per strobe of result_valid, one per pass of the
// controller through its read and evaluate states; when the list runs empty
// the last one follows the one before it in the next cycle. The last one has
// last_of_run high and shows in the first cycle with busy low. Results cannot
// be held off: the receiver must take each one in the cycle it is shown.
module inactivity_timeout_list_unit
	import itl_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] cur_time,
	// result channel
	output logic        result_valid,
	output logic [3:0]  expired_slot,
	output logic        last_of_run
);

	logic [15:0] timeout_q;
	itl_cmd_t    cmd;
	itl_sts_t    sts;
	itl_op_t     op_in;

	assign op_in  = itl_op_t'(op);
	assign pready = 1'b1;

	// timeout register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// register read decode
	always_comb begin
		unique case (paddr[2])
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:     prdata = '0;
		endcase
	end

	itl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op_in),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	itl_dpath #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op_in),
		.slot         (slot),
		.cur_time     (cur_time),
		.timeout      (timeout_q),
		.result_valid (result_valid),
		.expired_slot (expired_slot),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- verif/inactivity_timeout_list_unit_tb.sv -----
// testbench for the inactivity timeout list, checked against a local list model
module inactivity_timeout_list_unit_tb
	import itl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = 16;
	localparam logic [4:0] LINK_NIL = 5'd16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	// one command transaction and one expiry result
	typedef struct packed {
		itl_op_t     op;
		logic [3:0]  slot;
		logic [31:0] now;
	} watch_cmd_t;

	typedef struct packed {
		logic [3:0] slot;
		logic       last_run;
	} expiry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        start = 1'b0;
	wire         busy;
	itl_op_t     op = OP_NONE;
	logic [3:0]  slot = '0;
	logic [31:0] cur_time = '0;
	wire         result_valid;
	wire  [3:0]  expired_slot;
	wire         last_of_run;

	inactivity_timeout_list_unit #(
		.SLOTS(SLOT_COUNT),
		.TIME_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.op(op),
		.slot(slot),
		.cur_time(cur_time),
		.result_valid(result_valid),
		.expired_slot(expired_slot),
		.last_of_run(last_of_run)
	);

	// watched list model
	logic [31:0] wd_alarm [SLOT_COUNT];
	logic [4:0]  wd_older [SLOT_COUNT];
	logic [4:0]  wd_newer [SLOT_COUNT];
	logic        wd_listed [SLOT_COUNT];
	logic [4:0]  wd_oldest = LINK_NIL;
	logic [4:0]  wd_newest = LINK_NIL;
	logic [15:0] wd_timeout = TIMEOUT_RESET;

	watch_cmd_t  pending_q [$];
	expiry_t     expiry_q [$];
	int          issued_count = 0;
	int          accepted_count = 0;
	int          err_count = 0;
	int          expiries_seen = 0;
	int          cycle_count = 0;
	int          send_gap_pct = 0;
	logic [31:0] wall_now = '0;
	logic [15:0] mid_timeout;

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			wd_listed[i] = 1'b0;
		end
	end

	// take a slot out of the list if it is there
	function automatic void detach_slot(input logic [3:0] s);
		logic [4:0] o;
		logic [4:0] n;
		if (!wd_listed[s])
			return;
		o = wd_older[s];
		n = wd_newer[s];
		if (n == LINK_NIL)
			wd_newest = o;
		else
			wd_older[n[3:0]] = o;
		if (o == LINK_NIL)
			wd_oldest = n;
		else
			wd_newer[o[3:0]] = n;
		wd_older[s] = LINK_NIL;
		wd_newer[s] = LINK_NIL;
		wd_listed[s] = 1'b0;
	endfunction

	// put a slot at the newest end with a saturated, order-preserving alarm
	function automatic void attach_slot(input logic [3:0] s, input logic [31:0] now);
		logic [32:0] sum;
		logic [31:0] alarm;
		sum = {1'b0, now} + {17'd0, wd_timeout};
		alarm = sum[32] ? TIME_MAX : sum[31:0];
		if (wd_newest != LINK_NIL && wd_alarm[wd_newest[3:0]] > alarm)
			alarm = wd_alarm[wd_newest[3:0]];
		wd_alarm[s] = alarm;
		wd_older[s] = wd_newest;
		wd_newer[s] = LINK_NIL;
		if (wd_oldest == LINK_NIL)
			wd_oldest = {1'b0, s};
		else
			wd_newer[wd_newest[3:0]] = {1'b0, s};
		wd_newest = {1'b0, s};
		wd_listed[s] = 1'b1;
	endfunction

	// apply one accepted transaction and queue the expiries it causes
	function automatic void apply_watch_cmd(input watch_cmd_t c);
		int count;
		logic [3:0] s;
		logic more;
		count = 0;
		case (c.op)
			OP_ARM: begin
				detach_slot(c.slot);
				attach_slot(c.slot, c.now);
			end
			OP_REMOVE: begin
				detach_slot(c.slot);
			end
			OP_TICK: begin
				while (wd_oldest != LINK_NIL && count < SLOT_COUNT &&
						c.now > wd_alarm[wd_oldest[3:0]]) begin
					s = wd_oldest[3:0];
					detach_slot(s);
					count++;
					more = wd_oldest != LINK_NIL && count < SLOT_COUNT &&
						c.now > wd_alarm[wd_oldest[3:0]];
					expiry_q.push_back('{slot: s, last_run: !more});
				end
			end
			default: begin
			end
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("inactivity_timeout_list_unit_tb: errors");
			$finish;
		end
	end

	// command driver, fed from the pending queue
	always @(negedge clk) begin
		watch_cmd_t nxt;
		logic free;
		free = !start || (accepted_count == issued_count);
		if (arst_n && free) begin
			if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				nxt = pending_q.pop_front();
				op <= nxt.op;
				slot <= nxt.slot;
				cur_time <= nxt.now;
				issued_count++;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, predict accepted transactions, track the register
	always @(posedge clk) begin
		expiry_t exp_item;
		watch_cmd_t c;
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				if (expiry_q.size() == 0) begin
					$error("unexpected expiry: expired_slot %0d last_of_run %0b",
						expired_slot, last_of_run);
					err_count++;
				end else begin
					exp_item = expiry_q.pop_front();
					expiries_seen++;
					if (expired_slot !== exp_item.slot) begin
						$error("expired_slot: expected %0d, got %0d", exp_item.slot,
							expired_slot);
						err_count++;
					end
					if (last_of_run !== exp_item.last_run) begin
						$error("last_of_run: expected %0b, got %0b", exp_item.last_run,
							last_of_run);
						err_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				c.op = op;
				c.slot = slot;
				c.now = cur_time;
				apply_watch_cmd(c);
				accepted_count <= accepted_count + 1;
			end
			if (psel && penable && pready === 1'b1 && paddr[2] == REG_TIMEOUT) begin
				if (pwrite) begin
					wd_timeout = pwdata[15:0];
				end else if (prdata[15:0] !== wd_timeout) begin
					$error("timeout_seconds: expected %0d, got %0d", wd_timeout,
						prdata[15:0]);
					err_count++;
				end
			end
		end
	end

	task automatic push_cmd(input itl_op_t o, input logic [3:0] s, input logic [31:0] t);
		pending_q.push_back('{op: o, slot: s, now: t});
	endtask

	// hold the sender until every transaction is done and every expiry has come
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_q.size() != 0 || issued_count != accepted_count ||
			expiry_q.size() != 0 || busy !== 1'b0);
	endtask

	// register write followed by a read back
	task automatic set_timeout(input logic [15:0] value);
		repeat (4) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TIMEOUT, 2'b00};
		pwdata <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// random phase: one full fill and expire, then mostly timed arms and ticks
	task automatic queue_random(input int count, input int tmo);
		int perm [SLOT_COUNT];
		int j;
		int tmp;
		int kind;
		logic [3:0] s;
		wall_now = $urandom_range(0, 32'h0FFF_FFFF);
		for (int i = 0; i < SLOT_COUNT; i++)
			perm[i] = i;
		for (int i = SLOT_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			push_cmd(OP_ARM, 4'(perm[i]), wall_now);
			wall_now += $urandom_range(0, 3);
		end
		push_cmd(OP_TICK, 4'($urandom), wall_now + tmo + 1);
		for (int n = SLOT_COUNT + 1; n < count; n++) begin
			kind = $urandom_range(0, 99);
			s = 4'($urandom);
			if (kind < 50) begin
				push_cmd(OP_ARM, s, wall_now);
				wall_now += $urandom_range(0, tmo / 4 + 1);
			end else if (kind < 66) begin
				push_cmd(OP_TICK, 4'($urandom), wall_now);
				wall_now += $urandom_range(0, tmo);
			end else if (kind < 80) begin
				push_cmd(OP_REMOVE, s, $urandom);
			end else if (kind < 85) begin
				push_cmd(OP_NONE, s, $urandom);
			end else if (kind < 92) begin
				push_cmd(OP_TICK, s, $urandom);
			end else if (kind < 96) begin
				push_cmd(OP_ARM, s, $urandom);
			end else begin
				// arm near the top of time, flush the rest, then drop it
				push_cmd(OP_ARM, s, TIME_MAX - $urandom_range(0, 2 * tmo));
				push_cmd(OP_TICK, 4'($urandom), TIME_MAX);
				push_cmd(OP_REMOVE, s, $urandom);
				n += 2;
			end
			if (wall_now > 32'hF000_0000)
				wall_now = $urandom_range(0, 32'h0FFF_FFFF);
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, ignored ops, full list, defer, equal alarm, saturation
		send_gap_pct = 0;
		push_cmd(OP_TICK, 4'd0, 32'd0);
		push_cmd(OP_NONE, 4'd15, TIME_MAX);
		push_cmd(OP_REMOVE, 4'd7, 32'd0);
		for (int i = 0; i < SLOT_COUNT; i++)
			push_cmd(OP_ARM, 4'(i), (i == 14) ? 32'd20 : 32'(i * 10));
		push_cmd(OP_ARM, 4'd3, 32'd200);
		push_cmd(OP_TICK, 4'd5, 32'd300);
		push_cmd(OP_TICK, 4'd0, TIME_MAX);
		push_cmd(OP_ARM, 4'd9, 32'hFFFF_FF00);
		push_cmd(OP_ARM, 4'd2, 32'd0);
		push_cmd(OP_ARM, 4'd4, 32'd5);
		push_cmd(OP_REMOVE, 4'd2, 32'd0);
		push_cmd(OP_REMOVE, 4'd4, 32'd0);
		push_cmd(OP_REMOVE, 4'd9, 32'd0);
		wait_idle();

		// shortest timeout, sparse sender
		set_timeout(16'd1);
		send_gap_pct = 76;
		queue_random(60, 1);
		wait_idle();

		// longest timeout, back to back
		set_timeout(16'hFFFF);
		send_gap_pct = 0;
		queue_random(60, 65535);
		wait_idle();

		// random timeout, light gaps
		mid_timeout = 16'($urandom_range(2, 65534));
		set_timeout(mid_timeout);
		send_gap_pct = 13;
		queue_random(60, mid_timeout);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (expiry_q.size() != 0) begin
			$error("%0d expiries never came", expiry_q.size());
			err_count++;
		end
		$display("run: %0d transactions, %0d expiries checked", accepted_count, expiries_seen);
		$display("timeouts 300, 1, 65535 and %0d with sender gaps of 0, 76 and 13 percent",
			mid_timeout);
		if (err_count == 0)
			$display("inactivity_timeout_list_unit_tb: clean");
		else
			$display("inactivity_timeout_list_unit_tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/itl_pkg.sv
design/itl_ctrl.sv
design/itl_dpath.sv
design/inactivity_timeout_list_unit.sv
verif/inactivity_timeout_list_unit_tb.sv
